/* rtl/wavetable_voice_register_writer_defines.svh */
// Assertion macros shared by the checkers of the voice register writer.
// No dependencies; include by bare file name.
`ifndef WAVETABLE_VOICE_REGISTER_WRITER_DEFINES_SVH
`define WAVETABLE_VOICE_REGISTER_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WVRW_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WVRW_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wvrw_pkg.sv */
// Shared types, codes and the note frequency table of the voice register writer.
// No dependencies.
package wvrw_pkg;

   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_CONTROL  = 2'd2;

   localparam logic [6:0] CTRL_WAVE    = 7'd1;
   localparam logic [6:0] CTRL_VOLUME  = 7'd7;
   localparam logic [6:0] CTRL_ALL_OFF = 7'd123;

   localparam logic [6:0] FIRST_NOTE = 7'd21;
   localparam int         NOTE_COUNT = 107;

   // Write sequence kinds
   localparam logic [1:0] KIND_NOTE_ON = 2'd0;
   localparam logic [1:0] KIND_SILENCE = 2'd1;
   localparam logic [1:0] KIND_WAVE    = 2'd2;
   localparam logic [1:0] KIND_VOLUME  = 2'd3;

   localparam logic [2:0] STEP_LAST_NOTE_ON = 3'd7;
   localparam logic [2:0] STEP_LAST_SILENCE = 3'd3;
   localparam logic [2:0] STEP_LAST_SINGLE  = 3'd0;

   localparam logic [7:0] FREQ_HIGH_FLAG = 8'h80;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  block;     // register block, address bits 6:3
      logic [17:0] freq;
      logic [1:0]  wave;
      logic [7:0]  vol_byte;  // volume register byte, count bits included
   } wvrw_job_type;

   localparam logic [17:0] FREQ_TABLE [NOTE_COUNT] = '{
      18'd61,    18'd64,    18'd68,    18'd72,    18'd77,    18'd81,
      18'd86,    18'd91,    18'd96,    18'd102,   18'd108,   18'd115,
      18'd121,   18'd129,   18'd136,   18'd145,   18'd153,   18'd162,
      18'd172,   18'd182,   18'd193,   18'd204,   18'd217,   18'd229,
      18'd243,   18'd257,   18'd273,   18'd289,   18'd306,   18'd324,
      18'd344,   18'd364,   18'd386,   18'd409,   18'd433,   18'd459,
      18'd486,   18'd515,   18'd546,   18'd578,   18'd613,   18'd649,
      18'd688,   18'd729,   18'd772,   18'd818,   18'd867,   18'd918,
      18'd973,   18'd1031,  18'd1092,  18'd1157,  18'd1226,  18'd1298,
      18'd1375,  18'd1457,  18'd1544,  18'd1636,  18'd1733,  18'd1836,
      18'd1945,  18'd2061,  18'd2183,  18'd2313,  18'd2451,  18'd2597,
      18'd2751,  18'd2914,  18'd3088,  18'd3271,  18'd3466,  18'd3672,
      18'd3890,  18'd4122,  18'd4367,  18'd4627,  18'd4902,  18'd5193,
      18'd5502,  18'd5829,  18'd6175,  18'd6542,  18'd6932,  18'd7344,
      18'd7780,  18'd8241,  18'd8733,  18'd9253,  18'd9804,  18'd10387,
      18'd11005, 18'd11659, 18'd12351, 18'd13085, 18'd13864, 18'd14689,
      18'd15561, 18'd16486, 18'd17467, 18'd18506, 18'd19609, 18'd20774,
      18'd22010, 18'd23318, 18'd24702, 18'd26170, 18'd27728
   };

endpackage

/* rtl/wvrw_ifs.sv */
// Valid/ready channel interfaces for voice events and register writes.
// No dependencies.
interface wvrw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [3:0] voice;
   logic [6:0] key_or_control;
   logic [6:0] level;

   modport source (output valid, cmd, voice, key_or_control, level, input ready);
   modport sink   (input valid, cmd, voice, key_or_control, level, output ready);
endinterface

interface wvrw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] reg_address;
   logic [7:0] reg_data;
   logic       last_write;

   modport source (output valid, reg_address, reg_data, last_write, input ready);
   modport sink   (input valid, reg_address, reg_data, last_write, output ready);
endinterface

/* rtl/wvrw_voice_state.sv */
// Per-voice state and event decode: turns one event into a write job.
// Depends on wvrw_pkg.
module wvrw_voice_state
   import wvrw_pkg::*;
#(
   parameter int VOICES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [1:0]   cmd,
   input  logic [3:0]   voice,
   input  logic [6:0]   key_or_control,
   input  logic [6:0]   level,
   output logic         job_load,
   output wvrw_job_type job
);

   localparam int         VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [3:0] BLOCK_0    = 4'(16 - VOICES);
   localparam logic [3:0] LAST_VOICE = 4'(VOICES - 1);
   localparam logic [2:0] COUNT_BITS = 3'(VOICES - 1);

   // Volume writes always carry the freshly written value, so only
   // the active flag and wave select are kept per voice.
   logic              active_ff [VOICES];
   logic              active_in;
   logic [1:0]        wave_ff [VOICES];
   logic [1:0]        wave_in;
   logic              state_we;

   logic              in_range;
   logic [VIDX_W-1:0] vidx;
   logic              is_note_on;
   logic              is_silence;
   logic              is_wave;
   logic              is_volume;
   logic [3:0]        vol;

   assign in_range = voice < 4'(VOICES);
   assign vidx     = voice[VIDX_W-1:0];

   always_comb begin
      is_note_on = 1'b0;
      is_silence = 1'b0;
      is_wave    = 1'b0;
      is_volume  = 1'b0;
      if (in_range) begin
         case (cmd)
            CMD_NOTE_ON:  is_note_on = key_or_control >= FIRST_NOTE;
            CMD_NOTE_OFF: is_silence = 1'b1;
            CMD_CONTROL: begin
               is_wave    = key_or_control == CTRL_WAVE;
               is_volume  = key_or_control == CTRL_VOLUME;
               is_silence = key_or_control == CTRL_ALL_OFF;
            end
            default: ;
         endcase
      end
   end

   // A wave change keeps the voice's active flag as it is.
   always_comb begin
      state_we  = accept && (is_note_on || is_silence || is_wave);
      active_in = is_note_on || (is_wave && active_ff[vidx]);
      wave_in   = is_wave ? level[6:5] : wave_ff[vidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= 1'b0;
            wave_ff[i]   <= 2'd0;
         end
      end else if (state_we) begin
         active_ff[vidx] <= active_in;
         wave_ff[vidx]   <= wave_in;
      end
   end

   always_comb begin
      vol = is_silence ? 4'd0 : level[6:3];

      job.block    = BLOCK_0 + voice;
      job.freq     = FREQ_TABLE[key_or_control - FIRST_NOTE];
      job.wave     = is_wave ? level[6:5] : wave_ff[vidx];
      job.vol_byte = {1'b0, (voice == LAST_VOICE) ? COUNT_BITS : 3'd0, vol};

      if (is_note_on)
         job.kind = KIND_NOTE_ON;
      else if (is_silence)
         job.kind = KIND_SILENCE;
      else if (is_wave)
         job.kind = KIND_WAVE;
      else
         job.kind = KIND_VOLUME;

      job_load = accept && (is_note_on || is_silence ||
                            ((is_wave || is_volume) && active_ff[vidx]));
   end

endmodule

/* rtl/wvrw_write_seq.sv */
// Job register, write step counter and result register of the voice register writer.
// Depends on wvrw_pkg and wvrw_rsp_if.
module wvrw_write_seq
   import wvrw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_load,
   input  wvrw_job_type job,
   output logic         job_free,
   wvrw_rsp_if.source   rsp_chan
);

   logic         job_valid_ff, job_valid_in;
   wvrw_job_type job_ff;
   logic [2:0]   step_ff, step_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [6:0]   addr_ff;
   logic [7:0]   data_ff;
   logic         last_ff;

   logic         advance;
   logic         last_step;
   logic [2:0]   step_last;
   logic [2:0]   offset;
   logic [7:0]   data;

   always_comb begin
      unique case (job_ff.kind)
         KIND_NOTE_ON: step_last = STEP_LAST_NOTE_ON;
         KIND_SILENCE: step_last = STEP_LAST_SILENCE;
         KIND_WAVE:    step_last = STEP_LAST_SINGLE;
         KIND_VOLUME:  step_last = STEP_LAST_SINGLE;
         default:      step_last = STEP_LAST_SINGLE;
      endcase
   end

   // Register offset and byte for the current step.
   always_comb begin
      offset = 3'd0;
      data   = 8'h00;
      unique case (job_ff.kind)
         KIND_NOTE_ON: begin
            case (step_ff)
               3'd0: offset = 3'd1;
               3'd1: offset = 3'd3;
               3'd2: offset = 3'd5;
               3'd3: begin
                  offset = 3'd0;
                  data   = job_ff.freq[7:0];
               end
               3'd4: begin
                  offset = 3'd2;
                  data   = job_ff.freq[15:8];
               end
               3'd5: begin
                  offset = 3'd4;
                  data   = FREQ_HIGH_FLAG | {6'd0, job_ff.freq[17:16]};
               end
               3'd6: begin
                  offset = 3'd6;
                  data   = {2'd0, job_ff.wave, 4'd0};
               end
               default: begin
                  offset = 3'd7;
                  data   = job_ff.vol_byte;
               end
            endcase
         end
         KIND_SILENCE: begin
            case (step_ff)
               3'd0: begin
                  offset = 3'd7;
                  data   = job_ff.vol_byte;
               end
               3'd1: offset = 3'd0;
               3'd2: offset = 3'd2;
               default: begin
                  offset = 3'd4;
                  data   = FREQ_HIGH_FLAG;
               end
            endcase
         end
         KIND_WAVE: begin
            offset = 3'd6;
            data   = {2'd0, job_ff.wave, 4'd0};
         end
         KIND_VOLUME: begin
            offset = 3'd7;
            data   = job_ff.vol_byte;
         end
         default: ;
      endcase
   end

   assign advance   = job_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign last_step = step_ff == step_last;
   assign job_free  = !job_valid_ff || (advance && last_step);

   always_comb begin
      job_valid_in = job_valid_ff;
      step_in      = step_ff;
      if (advance) begin
         step_in = step_ff + 3'd1;
         if (last_step)
            job_valid_in = 1'b0;
      end
      if (job_load) begin
         job_valid_in = 1'b1;
         step_in      = 3'd0;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_load)
         job_ff <= job;
      if (advance) begin
         addr_ff <= {job_ff.block, offset};
         data_ff <= data;
         last_ff <= last_step;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reg_address = addr_ff;
   assign rsp_chan.reg_data    = data_ff;
   assign rsp_chan.last_write  = last_ff;

endmodule

/* rtl/wavetable_voice_register_writer.sv */
// Voice events in, wavetable chip register writes out, one write per cycle while the output is not stalled.
// Each event is decoded in the cycle it is taken; a job register then plays its writes
// into the result register. A note on makes eight writes, a note off or all-notes-off four,
// a wave or volume control on an active voice one, and any other event none. The
// next event is taken in the cycle the last write of the previous one enters the result
// register, so the pace is set by the single write path: one register write per cycle unless stalled.
// Depends on wvrw_pkg and wvrw_ifs.
module wavetable_voice_register_writer
   import wvrw_pkg::*;
#(
   parameter int VOICES = 4
) (
   input  logic       clock,
   input  logic       reset,
   wvrw_req_if.sink   req_chan,
   wvrw_rsp_if.source rsp_chan
);

   logic         accept;
   logic         job_load;
   logic         job_free;
   wvrw_job_type job;

   assign req_chan.ready = job_free;
   assign accept         = req_chan.valid && job_free;

   wvrw_voice_state #(
      .VOICES (VOICES)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (req_chan.cmd),
      .voice          (req_chan.voice),
      .key_or_control (req_chan.key_or_control),
      .level          (req_chan.level),
      .job_load       (job_load),
      .job            (job)
   );

   wvrw_write_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .job_load (job_load),
      .job      (job),
      .job_free (job_free),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/wvrw_checker.sv */
// Port-level checks on the register write stream, bound to the top level.
// Depends on wavetable_voice_register_writer_defines.svh.
`include "wavetable_voice_register_writer_defines.svh"

module wvrw_checker #(
   parameter int VOICES = 4
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_reg_address,
   input logic [7:0] rsp_reg_data
);

   localparam logic [3:0] BLOCK_0 = 4'(16 - VOICES);

   `WVRW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")
   `WVRW_ASSERT_SAME(a_addr_range, clock, reset, rsp_valid, rsp_reg_address[6:3] >= BLOCK_0, "write outside voice registers")
   `WVRW_ASSERT_SAME(a_freq_high, clock, reset, rsp_valid && rsp_reg_address[2:0] == 3'd4, rsp_reg_data[7:2] == 6'b100000, "bad frequency high byte")
   `WVRW_ASSERT_SAME(a_phase_clear, clock, reset, rsp_valid && rsp_reg_address[0] && rsp_reg_address[2:0] != 3'd7, rsp_reg_data == 8'h00, "phase clear not zero")

endmodule

bind wavetable_voice_register_writer wvrw_checker #(
   .VOICES (VOICES)
) u_wvrw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_reg_address (rsp_chan.reg_address),
   .rsp_reg_data    (rsp_chan.reg_data)
);
